@@ hdl/pin_lock_byte_controller_top_macros.svh @@
// ----------------------------------------------------------------------------
// PIN lock byte controller assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PIN_LOCK_BYTE_CONTROLLER_TOP_MACROS_SVH
`define PIN_LOCK_BYTE_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("plc assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is asserted.
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("plc assertion failed: next-cycle implication");
`else
`define PLC_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/plc_pkg.sv @@
// ----------------------------------------------------------------------------
// PIN lock byte controller package
// Shared constants and types for the PIN lock byte controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plc_pkg;

    // Number of bytes in one PIN.
    localparam int PIN_BYTES = 4;
    // Width of the byte position counter inside one PIN group.
    localparam int POS_W = (PIN_BYTES > 1) ? $clog2(PIN_BYTES) : 1;

    localparam int BYTE_W  = 8;
    localparam int LIMIT_W = 4;

    // Command bytes accepted while idle.
    localparam logic [BYTE_W-1:0] CMD_CHECK = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_SET   = 8'h02;

    // Every PIN byte resets to the character '0'.
    localparam logic [BYTE_W-1:0] PIN_RESET_BYTE = 8'h30;

    // Attempt limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_CHECK = 2'd1,
        MODE_SET   = 2'd2
    } t_mode;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

@@ hdl/pin_lock_byte_controller_top.sv @@
// ----------------------------------------------------------------------------
// PIN lock byte controller
// Command decoder and PIN compare/store engine driven by received serial bytes.
// ----------------------------------------------------------------------------
// Results: the last byte of a group is held in the input register; its result
// is loaded into the result register when that byte is processed.
// Throughput: one byte per cycle; the input register is held only when the
// byte would produce a result and the result register is full and stalled.
// Reset (i_rst_n low, synchronous): idle mode, failure count zero, PIN set to
// four '0' characters, attempt limit 3, both pipeline registers empty.
`timescale 1ns / 1ps
`include "pin_lock_byte_controller_top_macros.svh"

module pin_lock_byte_controller_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Byte input channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [plc_pkg::BYTE_W-1:0]   i_rx_byte,
    // Result output channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_reply_byte,
    output logic                         o_unlock_event,
    output logic                         o_alarm_event,
    // Configuration write channel for the attempt limit.
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [plc_pkg::LIMIT_W-1:0]  i_cfg_data
);
    import plc_pkg::*;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // Input register: one received byte waiting to be decoded.
    logic               r_in_vld;
    t_byte              r_in_byte;

    // Controller state.
    t_mode              r_mode,      n_mode;
    logic [POS_W-1:0]   r_pos,       n_pos;
    logic               r_mis,       n_mis;
    logic [LIMIT_W-1:0] r_fail,      n_fail;
    t_byte              r_pin [PIN_BYTES];
    t_byte              n_pin [PIN_BYTES];
    logic [LIMIT_W-1:0] r_limit;

    // Result register.
    logic               r_out_vld;
    logic               r_reply;
    logic               r_unlock;
    logic               r_alarm;

    // Decision outputs for the byte held in the input register.
    logic               n_res;
    logic               n_reply;
    logic               n_unlock;
    logic               n_alarm;

    logic               out_free;
    logic               proc_go;
    logic               in_accept;
    logic               last_byte;
    logic               mis_now;
    logic [LIMIT_W-1:0] fail_inc;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    // The result register can take a new transaction when it is empty or
    // its current transaction leaves this cycle. A byte that produces no
    // result never waits on the output side.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign proc_go    = r_in_vld && (out_free || !n_res);
    assign o_in_stall = r_in_vld && !proc_go;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The limit register is always writable.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (proc_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_limit <= i_cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Decision logic
    // ------------------------------------------------------------------
    // The last byte of a PIN group closes the group; a mismatch on any byte
    // of the group is remembered until then. The failure test uses >= so a
    // limit of zero behaves like one and a lowered limit fires on the next miss.
    assign last_byte = (r_pos == POS_W'(PIN_BYTES - 1));
    assign mis_now   = r_mis || (r_pin[r_pos] != r_in_byte);
    assign fail_inc  = r_fail + LIMIT_W'(1);

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_mis    = r_mis;
        n_fail   = r_fail;
        n_pin    = r_pin;
        n_res    = 1'b0;
        n_reply  = 1'b0;
        n_unlock = 1'b0;
        n_alarm  = 1'b0;

        case (r_mode)
            MODE_CHECK: begin
                if (!last_byte) begin
                    n_pos = r_pos + POS_W'(1);
                    n_mis = mis_now;
                end else begin
                    n_pos = '0;
                    n_res = 1'b1;
                    if (mis_now) begin
                        n_mis = 1'b0;
                        if (fail_inc >= r_limit) begin
                            n_fail  = '0;
                            n_mode  = MODE_IDLE;
                            n_alarm = 1'b1;
                        end else begin
                            n_fail = fail_inc;
                        end
                    end else begin
                        n_fail   = '0;
                        n_mode   = MODE_IDLE;
                        n_reply  = 1'b1;
                        n_unlock = 1'b1;
                    end
                end
            end
            MODE_SET: begin
                n_pin[r_pos] = r_in_byte;
                if (!last_byte) begin
                    n_pos = r_pos + POS_W'(1);
                end else begin
                    n_pos   = '0;
                    n_mode  = MODE_IDLE;
                    n_res   = 1'b1;
                    n_reply = 1'b1;
                end
            end
            default: begin
                // Idle: only the two command bytes leave this mode.
                n_mode = MODE_IDLE;
                n_pos  = '0;
                n_mis  = 1'b0;
                if (r_in_byte == CMD_CHECK) begin
                    n_mode = MODE_CHECK;
                end else if (r_in_byte == CMD_SET) begin
                    n_mode = MODE_SET;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_pos  <= '0;
            r_mis  <= 1'b0;
            r_fail <= '0;
            for (int k = 0; k < PIN_BYTES; k++) begin
                r_pin[k] <= PIN_RESET_BYTE;
            end
        end else if (proc_go) begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            r_mis  <= n_mis;
            r_fail <= n_fail;
            r_pin  <= n_pin;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= proc_go && n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_go && n_res) begin
            r_reply  <= n_reply;
            r_unlock <= n_unlock;
            r_alarm  <= n_alarm;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_reply_byte   = r_reply;
    assign o_unlock_event = r_unlock;
    assign o_alarm_event  = r_alarm;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PLC_ASSERT_IMPLY(a_unlock_alarm_excl, i_clk, i_rst_n,
                      o_out_valid, !(o_unlock_event && o_alarm_event))
    `PLC_ASSERT_IMPLY(a_unlock_replies_one, i_clk, i_rst_n,
                      o_out_valid && o_unlock_event, o_reply_byte)
    `PLC_ASSERT_NEXT(a_unlock_to_idle, i_clk, i_rst_n,
                     proc_go && n_unlock, (r_mode == MODE_IDLE) && (r_fail == '0))
    `PLC_ASSERT_IMPLY(a_idle_pos_zero, i_clk, i_rst_n, r_mode == MODE_IDLE, r_pos == '0)

endmodule

@@ sim/tb_pin_lock_byte_controller_top.sv @@
// ----------------------------------------------------------------------------
// PIN lock byte controller testbench
// Drives serial bytes into the lock, predicts every reply, unlock and alarm,
// and checks each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pin_lock_byte_controller_top;

    import plc_pkg::*;

    // A run fails if this many cycles pass with no transaction on any channel.
    localparam int QUIET_LIMIT  = 5000;
    // Cycles waited once every owed result is out, to cover bytes that are still
    // in flight but produce nothing.
    localparam int DRAIN_CYCLES = 6;
    // Bytes that the lock acts on, per random phase.
    localparam int PHASE_ITEMS  = 70;
    localparam int SHOWN_ERRORS = 10;

    // One result transaction, in the order of the output ports.
    typedef struct packed {
        logic reply;
        logic unlock;
        logic alarm;
    } t_verdict;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    t_byte               i_rx_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_reply_byte;
    logic                o_unlock_event;
    logic                o_alarm_event;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_data;

    pin_lock_byte_controller_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_reply_byte   (o_reply_byte),
        .o_unlock_event (o_unlock_event),
        .o_alarm_event  (o_alarm_event),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Lock model. It mirrors the lock's state and is advanced once for every
    // byte the block accepts, at the same clock edge. Results that the lock
    // owes are queued in pending_verdicts in the order they must come out.
    // ------------------------------------------------------------------------
    t_mode               lock_mode;
    logic [POS_W-1:0]    lock_pos;
    logic                lock_mismatch;
    logic [LIMIT_W-1:0]  lock_fails;
    logic [LIMIT_W-1:0]  lock_limit;
    t_byte               lock_pin [PIN_BYTES];
    t_verdict            pending_verdicts [$];

    // Returns 1 when the byte did something (a command or a PIN byte), 0 when
    // the idle lock simply dropped it.
    function automatic bit advance_lock_model(t_byte b);
        t_verdict v;
        bit       last;
        last = (int'(lock_pos) + 1) >= PIN_BYTES;
        case (lock_mode)
            MODE_CHECK: begin
                if (lock_pin[lock_pos] != b) lock_mismatch = 1'b1;
                if (!last) begin
                    lock_pos = lock_pos + POS_W'(1);
                    return 1'b1;
                end
                lock_pos = '0;
                if (lock_mismatch) begin
                    lock_mismatch = 1'b0;
                    lock_fails    = lock_fails + LIMIT_W'(1);
                    // The test is >=, so a limit of zero behaves like one and a
                    // limit lowered below the count fires on the next miss.
                    if (lock_fails >= lock_limit) begin
                        lock_fails = '0;
                        lock_mode  = MODE_IDLE;
                        v = '{reply: 1'b0, unlock: 1'b0, alarm: 1'b1};
                    end else begin
                        v = '{reply: 1'b0, unlock: 1'b0, alarm: 1'b0};
                    end
                end else begin
                    lock_fails = '0;
                    lock_mode  = MODE_IDLE;
                    v = '{reply: 1'b1, unlock: 1'b1, alarm: 1'b0};
                end
                pending_verdicts.push_back(v);
                return 1'b1;
            end
            MODE_SET: begin
                lock_pin[lock_pos] = b;
                if (!last) begin
                    lock_pos = lock_pos + POS_W'(1);
                    return 1'b1;
                end
                lock_pos  = '0;
                lock_mode = MODE_IDLE;
                v = '{reply: 1'b1, unlock: 1'b0, alarm: 1'b0};
                pending_verdicts.push_back(v);
                return 1'b1;
            end
            default: begin
                lock_pos      = '0;
                lock_mismatch = 1'b0;
                lock_mode     = MODE_IDLE;
                if (b == CMD_CHECK) begin
                    lock_mode = MODE_CHECK;
                    return 1'b1;
                end
                if (b == CMD_SET) begin
                    lock_mode = MODE_SET;
                    return 1'b1;
                end
                return 1'b0;
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and the watchdog counter. Outputs are sampled at the
    // rising edge, before the block's own registers move.
    // ------------------------------------------------------------------------
    int mismatch_count;
    int result_count;
    int unlock_count;
    int alarm_count;
    int quiet_cycles;

    always @(posedge i_clk) begin : result_check
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (o_out_valid && !i_out_stall) begin
                got = '{reply: o_reply_byte, unlock: o_unlock_event, alarm: o_alarm_event};
                result_count++;
                if (got.unlock) unlock_count++;
                if (got.alarm) alarm_count++;
                if (pending_verdicts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOWN_ERRORS)
                        $display("ERROR: unexpected result reply=%0b unlock=%0b alarm=%0b",
                                 got.reply, got.unlock, got.alarm);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got != want) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOWN_ERRORS)
                            $display("ERROR: result %0d expected r/u/a=%0b%0b%0b got %0b%0b%0b",
                                     result_count, want.reply, want.unlock, want.alarm,
                                     got.reply, got.unlock, got.alarm);
                    end
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("ERROR: no transaction for %0d cycles, %0d results still owed",
                 QUIET_LIMIT, pending_verdicts.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Back-pressure on the result channel, redrawn every falling edge.
    // ------------------------------------------------------------------------
    int send_idle_pct;
    int recv_stall_pct;

    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Shared drivers.
    // ------------------------------------------------------------------------
    int live_items;

    // Sends one byte. Valid goes up at a falling edge after a random number of
    // idle cycles and is only changed again at the next call, so a byte that
    // follows directly keeps valid high with one assignment.
    task automatic send_byte(input t_byte b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        if (advance_lock_model(b)) live_items++;
    endtask

    // Four PIN bytes, the first one in the top byte.
    task automatic send_group(input logic [8*PIN_BYTES-1:0] group);
        for (int k = PIN_BYTES - 1; k >= 0; k--) send_byte(group[8*k +: 8]);
    endtask

    // Stops traffic and waits until every owed result is out and the pipeline
    // has had time to swallow bytes that produce nothing.
    task automatic drain_lock;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (pending_verdicts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain_lock();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        lock_limit = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------------

    // Junk bytes are dropped while idle; the reset PIN "0000" then unlocks.
    task automatic test_reset_pin;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h03);
        send_byte(8'h80);
        send_byte(CMD_CHECK);
        send_group({4{PIN_RESET_BYTE}});
    endtask

    // Three wrong entries at the reset limit: two plain misses, then the alarm.
    task automatic test_default_alarm;
        send_byte(CMD_CHECK);
        send_group(32'h3130_3030);
        send_group(32'hFFFF_FFFF);
        send_group(32'h0000_0000);
    endtask

    // Store a new PIN with extreme bytes and unlock with it.
    task automatic test_store_pin;
        send_byte(CMD_SET);
        send_group(32'hFF00_55AA);
        send_byte(CMD_CHECK);
        send_group(32'hFF00_55AA);
    endtask

    // A limit of zero and of one alarm at the first miss; fifteen at the
    // fifteenth, after fourteen plain misses.
    task automatic test_limit_extremes;
        write_limit(4'd0);
        send_byte(CMD_CHECK);
        send_group(32'h0102_0304);
        write_limit(4'd15);
        send_byte(CMD_CHECK);
        repeat (15) send_group(32'h3030_3030);
        write_limit(4'd1);
        send_byte(CMD_CHECK);
        send_group(32'hFF00_55AB);
    endtask

    // The limit drops below the running count while the lock waits in check
    // mode; the next miss must raise the alarm.
    task automatic test_lowered_limit;
        write_limit(4'd15);
        send_byte(CMD_CHECK);
        repeat (3) send_group(32'h1234_5678);
        write_limit(4'd2);
        send_group(32'h8765_4321);
    endtask

    // ------------------------------------------------------------------------
    // Random phase. Most traffic is whole check or set sequences, with a mix
    // of right and wrong PINs so that unlocks and alarms both happen; the rest
    // is stray bytes and sequences cut short.
    // ------------------------------------------------------------------------
    task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                    input logic [LIMIT_W-1:0] limit);
        int    pick;
        int    cut;
        t_byte entry [PIN_BYTES];
        write_limit(limit);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        live_items     = 0;
        while (live_items < PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                // Check entry; the command is only needed from idle.
                for (int k = 0; k < PIN_BYTES; k++) entry[k] = lock_pin[k];
                if ($urandom_range(1))
                    entry[$urandom_range(PIN_BYTES - 1)] ^= t_byte'($urandom_range(1, 255));
                if (lock_mode == MODE_IDLE) send_byte(CMD_CHECK);
                for (int k = 0; k < PIN_BYTES; k++) send_byte(entry[k]);
            end else if (pick < 70) begin
                if (lock_mode == MODE_IDLE) send_byte(CMD_SET);
                for (int k = 0; k < PIN_BYTES; k++) begin
                    case ($urandom_range(7))
                        0:       send_byte(CMD_CHECK);
                        1:       send_byte(CMD_SET);
                        2:       send_byte(PIN_RESET_BYTE);
                        default: send_byte(t_byte'($urandom_range(255)));
                    endcase
                end
            end else if (pick < 85) begin
                send_byte(t_byte'($urandom_range(255)));
            end else begin
                // A command followed by a partial group.
                send_byte($urandom_range(1) ? CMD_CHECK : CMD_SET);
                cut = $urandom_range(PIN_BYTES - 1);
                repeat (cut) send_byte(t_byte'($urandom_range(255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_rx_byte      = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        result_count   = 0;
        unlock_count   = 0;
        alarm_count    = 0;
        live_items     = 0;
        lock_mode      = MODE_IDLE;
        lock_pos       = '0;
        lock_mismatch  = 1'b0;
        lock_fails     = '0;
        lock_limit     = LIMIT_RESET;
        for (int k = 0; k < PIN_BYTES; k++) lock_pin[k] = PIN_RESET_BYTE;

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_pin();
        test_default_alarm();
        test_store_pin();
        test_limit_extremes();
        test_lowered_limit();

        // No idling, then a slow sender, a slow receiver, and both at once.
        run_random_phase(0, 0, 4'd15);
        run_random_phase(68, 0, 4'd1);
        run_random_phase(0, 68, 4'(($urandom_range(1, 15))));
        run_random_phase(20, 20, 4'(($urandom_range(1, 4))));

        drain_lock();

        $display("Run covered reset PIN, stored PINs, limits 0 to 15 and a lowered limit,");
        $display("with %0d results checked: %0d unlocks and %0d alarms.",
                 result_count, unlock_count, alarm_count);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_verdicts.size());
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/plc_pkg.sv
hdl/pin_lock_byte_controller_top.sv
sim/tb_pin_lock_byte_controller_top.sv
